[rtl/i2cbm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared opcodes, command kinds and the queue entry that links the front and
// back halves of the master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Bits shifted per byte transfer.
    localparam int BYTE_BITS = 8;
    localparam int BIT_IDX_W = $clog2(BYTE_BITS);
    localparam int COUNT_W   = $clog2(BYTE_BITS + 1);

    // Request opcodes as they arrive on the command channel.
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_SEND_ACK = 3'd4;
    localparam logic [2:0] OP_RECV_ACK = 3'd5;
    localparam logic [2:0] OP_SAMPLE   = 3'd6;

    // What the front tracks about an outstanding read.
    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_BYTE = 2'd1,
        WAIT_ACK  = 2'd2
    } wait_kind_t;

    // Classified work handed to the back half.
    typedef enum logic [2:0] {
        KIND_ERROR       = 3'd0,
        KIND_START       = 3'd1,
        KIND_STOP        = 3'd2,
        KIND_WRITE       = 3'd3,
        KIND_SEND_ACK    = 3'd4,
        KIND_READ_BEGIN  = 3'd5,
        KIND_SAMPLE_MORE = 3'd6,
        KIND_SAMPLE_DONE = 3'd7
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   want;     // sample_wanted shown on an error step
        logic [BYTE_BITS-1:0]   payload;  // write byte, ack level or read result
    } queue_entry_t;

endpackage

[rtl/i2cbm_if.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master channels
// Valid/ready channels for incoming requests and outgoing line steps.
// ----------------------------------------------------------------------------
interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_sample;

    modport source (output valid, op, data_byte, ack_bit, sda_sample, input ready);
    modport sink   (input valid, op, data_byte, ack_bit, sda_sample, output ready);
endinterface

interface i2cbm_step_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda;
    logic       sample_wanted;
    logic [7:0] read_value;
    logic       read_valid;
    logic       error;
    logic       last;

    modport source (output valid, scl, sda, sample_wanted, read_value, read_valid,
                    error, last, input ready);
    modport sink   (input valid, scl, sda, sample_wanted, read_value, read_valid,
                    error, last, output ready);
endinterface

[rtl/i2cbm_front.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master front end
// Accepts requests, tracks the read phase and classifies each request into
// one queued command for the back end.
// ----------------------------------------------------------------------------
module i2cbm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    i2cbm_cmd_if.sink              cmd,
    input  logic                   full,
    output logic                   push,
    output i2cbm_pkg::queue_entry_t entry
);

    i2cbm_pkg::wait_kind_t                   wait_reg, wait_next;
    logic [i2cbm_pkg::COUNT_W-1:0]           count_reg, count_next, count_inc;
    logic [i2cbm_pkg::BYTE_BITS-1:0]         shift_reg, shift_next, shift_in;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    always_comb
    begin
        entry.kind    = i2cbm_pkg::KIND_ERROR;
        entry.want    = (wait_reg != i2cbm_pkg::WAIT_NONE);
        entry.payload = '0;
        wait_next     = wait_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        count_inc     = count_reg + 1'b1;
        shift_in      = {shift_reg[i2cbm_pkg::BYTE_BITS-2:0], cmd.sda_sample};

        if (wait_reg == i2cbm_pkg::WAIT_NONE)
        begin
            unique case (cmd.op)
                i2cbm_pkg::OP_START:
                begin
                    entry.kind = i2cbm_pkg::KIND_START;
                end
                i2cbm_pkg::OP_STOP:
                begin
                    entry.kind = i2cbm_pkg::KIND_STOP;
                end
                i2cbm_pkg::OP_WRITE:
                begin
                    entry.kind    = i2cbm_pkg::KIND_WRITE;
                    entry.payload = cmd.data_byte;
                end
                i2cbm_pkg::OP_READ:
                begin
                    entry.kind = i2cbm_pkg::KIND_READ_BEGIN;
                    wait_next  = i2cbm_pkg::WAIT_BYTE;
                    count_next = '0;
                    shift_next = '0;
                end
                i2cbm_pkg::OP_SEND_ACK:
                begin
                    entry.kind    = i2cbm_pkg::KIND_SEND_ACK;
                    entry.payload = {{(i2cbm_pkg::BYTE_BITS-1){1'b0}}, cmd.ack_bit};
                end
                i2cbm_pkg::OP_RECV_ACK:
                begin
                    entry.kind = i2cbm_pkg::KIND_READ_BEGIN;
                    wait_next  = i2cbm_pkg::WAIT_ACK;
                end
                default:
                begin
                    // An unasked sample or an unused opcode stays an error.
                    entry.kind = i2cbm_pkg::KIND_ERROR;
                end
            endcase
        end
        else if (cmd.op == i2cbm_pkg::OP_SAMPLE)
        begin
            entry.want = 1'b0;
            if (wait_reg == i2cbm_pkg::WAIT_BYTE)
            begin
                shift_next = shift_in;
                count_next = count_inc;
                if (count_inc < i2cbm_pkg::COUNT_W'(i2cbm_pkg::BYTE_BITS))
                begin
                    entry.kind = i2cbm_pkg::KIND_SAMPLE_MORE;
                end
                else
                begin
                    entry.kind    = i2cbm_pkg::KIND_SAMPLE_DONE;
                    entry.payload = shift_in;
                    wait_next     = i2cbm_pkg::WAIT_NONE;
                end
            end
            else
            begin
                entry.kind    = i2cbm_pkg::KIND_SAMPLE_DONE;
                entry.payload = {{(i2cbm_pkg::BYTE_BITS-1){1'b0}}, cmd.sda_sample};
                wait_next     = i2cbm_pkg::WAIT_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg  <= i2cbm_pkg::WAIT_NONE;
            count_reg <= '0;
            shift_reg <= '0;
        end
        else if (push)
        begin
            wait_reg  <= wait_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

endmodule

[rtl/i2cbm_queue.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master command queue
// Small FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module i2cbm_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  i2cbm_pkg::queue_entry_t push_entry,
    output logic                    full,
    output logic                    head_valid,
    output i2cbm_pkg::queue_entry_t head,
    input  logic                    pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cbm_pkg::queue_entry_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/i2cbm_back.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master back end
// Plays each queued command out as a run of SCL/SDA steps into an output register,
// one per cycle while the step sink keeps up.
// ----------------------------------------------------------------------------
module i2cbm_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  i2cbm_pkg::queue_entry_t head,
    output logic                    pop,
    i2cbm_step_if.source            step
);

    logic                              scl_reg, sda_reg, scl_next, sda_next;
    logic [1:0]                        phase_reg, phase_next;
    logic [i2cbm_pkg::BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic                              out_valid_reg;
    logic                              want_next, rvalid_next, err_next, last_next;
    logic [i2cbm_pkg::BYTE_BITS-1:0]   value_next;
    logic                              advance;

    logic                              want_reg, rvalid_reg, err_reg, last_reg;
    logic [i2cbm_pkg::BYTE_BITS-1:0]   value_reg;

    assign advance = head_valid && (!out_valid_reg || step.ready);
    assign pop     = advance && last_next;

    always_comb
    begin
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        want_next   = 1'b0;
        value_next  = '0;
        rvalid_next = 1'b0;
        err_next    = 1'b0;
        last_next   = 1'b0;

        unique case (head.kind)
            i2cbm_pkg::KIND_START:
            begin
                case (phase_reg)
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    sda_next = 1'b0;
                    default:
                    begin
                        scl_next  = 1'b0;
                        last_next = 1'b1;
                    end
                endcase
            end
            i2cbm_pkg::KIND_STOP:
            begin
                case (phase_reg)
                    2'd0:    sda_next = 1'b0;
                    2'd1:    scl_next = 1'b1;
                    default:
                    begin
                        sda_next  = 1'b1;
                        last_next = 1'b1;
                    end
                endcase
            end
            i2cbm_pkg::KIND_WRITE:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        sda_next = head.payload[
                            i2cbm_pkg::BIT_IDX_W'(i2cbm_pkg::BYTE_BITS - 1) - bit_reg];
                    end
                    2'd1:    scl_next = 1'b1;
                    default:
                    begin
                        scl_next  = 1'b0;
                        last_next = (bit_reg ==
                                     i2cbm_pkg::BIT_IDX_W'(i2cbm_pkg::BYTE_BITS - 1));
                    end
                endcase
            end
            i2cbm_pkg::KIND_SEND_ACK:
            begin
                case (phase_reg)
                    2'd0:    sda_next = head.payload[0];
                    2'd1:    scl_next = 1'b1;
                    default:
                    begin
                        scl_next  = 1'b0;
                        last_next = 1'b1;
                    end
                endcase
            end
            i2cbm_pkg::KIND_READ_BEGIN:
            begin
                if (phase_reg == 2'd0)
                begin
                    sda_next = 1'b1;
                end
                else
                begin
                    scl_next  = 1'b1;
                    want_next = 1'b1;
                    last_next = 1'b1;
                end
            end
            i2cbm_pkg::KIND_SAMPLE_MORE:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl_next = 1'b0;
                end
                else
                begin
                    scl_next  = 1'b1;
                    want_next = 1'b1;
                    last_next = 1'b1;
                end
            end
            i2cbm_pkg::KIND_SAMPLE_DONE:
            begin
                scl_next    = 1'b0;
                value_next  = head.payload;
                rvalid_next = 1'b1;
                last_next   = 1'b1;
            end
            i2cbm_pkg::KIND_ERROR:
            begin
                want_next = head.want;
                err_next  = 1'b1;
                last_next = 1'b1;
            end
        endcase

        if (last_next)
        begin
            phase_next = 2'd0;
            bit_next   = '0;
        end
        else if (head.kind == i2cbm_pkg::KIND_WRITE && phase_reg == 2'd2)
        begin
            phase_next = 2'd0;
            bit_next   = bit_reg + 1'b1;
        end
        else
        begin
            phase_next = phase_reg + 1'b1;
            bit_next   = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            phase_reg     <= 2'd0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                out_valid_reg <= 1'b1;
            end
            else if (step.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            want_reg   <= want_next;
            value_reg  <= value_next;
            rvalid_reg <= rvalid_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
        end
    end

    assign step.valid         = out_valid_reg;
    assign step.scl           = scl_reg;
    assign step.sda           = sda_reg;
    assign step.sample_wanted = want_reg;
    assign step.read_value    = value_reg;
    assign step.read_valid    = rvalid_reg;
    assign step.error         = err_reg;
    assign step.last          = last_reg;

endmodule

[rtl/i2c_bit_level_master.sv]
// Path: the first line step of a request enters the command queue when the request is
// accepted, then the back end's output register, which offers it on the step channel.
// Throughput: one line step per cycle from the back end while the step sink keeps up; a write
// byte is 24 line steps, start 4, stop and send ack 3, and reads, samples and errors 1 to 2;
// the front takes a request per cycle until the command queue of QUEUE_DEPTH entries is full.
// Reset: rst_n clears asynchronously; SCL and SDA return released high, no read pending.
// ----------------------------------------------------------------------------
// I2C bit-level master
// Command-driven master that turns start, stop, byte and ack requests into
// runs of SCL/SDA line steps and collects sampled SDA levels for reads.
// ----------------------------------------------------------------------------
module i2c_bit_level_master #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cbm_cmd_if.sink    cmd,
    i2cbm_step_if.source step
);

    // The front end keeps its own copy of the read phase (pending read kind,
    // bits received, bits so far). The phase depends only on the order of
    // requests, so every request is classified the moment it is accepted,
    // including errors for out-of-phase requests and the final byte value.
    i2cbm_pkg::queue_entry_t push_entry;
    i2cbm_pkg::queue_entry_t head;
    logic                    push;
    logic                    full;
    logic                    head_valid;
    logic                    pop;

    i2cbm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    // Classified commands wait here so that a stalled step sink does not hold
    // off new requests until the queue is full, and an idle request side does
    // not starve the back end while it plays out a long write.
    i2cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // The back end owns the actual line levels. Error steps repeat the
    // current lines, which are exact because commands execute in order.
    i2cbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .step       (step)
    );

endmodule

[rtl/i2cbm_check.sv]
// ----------------------------------------------------------------------------
// I2C bit-level master port checker
// Watches the step channel of the master and flags steps that cannot occur.
// ----------------------------------------------------------------------------
module i2cbm_check (
    input logic       clk,
    input logic       rst_n,
    input logic       step_valid,
    input logic       step_ready,
    input logic       scl,
    input logic       sda,
    input logic       sample_wanted,
    input logic       read_valid,
    input logic       error,
    input logic       last
);

    // A step that is held back must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && !step_ready |=> step_valid)
        else $error("step withdrawn while stalled");

    // An error produces exactly one step and never a read result.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && error |-> last && !read_valid)
        else $error("error step is not a lone final step");

    // A finished read ends its request with SCL low and no sample pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && read_valid |-> last && !sample_wanted && !scl)
        else $error("read result on a wrong step");

    // While a sample is awaited, both lines sit released high.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && sample_wanted |-> last && scl && sda)
        else $error("sample request with lines not released");

endmodule

bind i2c_bit_level_master i2cbm_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_valid    (step.valid),
    .step_ready    (step.ready),
    .scl           (step.scl),
    .sda           (step.sda),
    .sample_wanted (step.sample_wanted),
    .read_valid    (step.read_valid),
    .error         (step.error),
    .last          (step.last)
);
